[src/wgrq_pkg.sv]
`timescale 1ns / 1ps

package wgrq_pkg;

  localparam int unsigned NumCols  = 4;
  localparam int unsigned ElemW    = 32;
  localparam int unsigned ValueW   = 8;
  localparam int unsigned ProdW    = 2 * ElemW;
  localparam int unsigned FracW    = 24;

  localparam logic [1:0] ROW_M0 = 2'd0;
  localparam logic [1:0] ROW_M1 = 2'd1;
  localparam logic [1:0] ROW_M2 = 2'd2;
  localparam logic [1:0] ROW_M3 = 2'd3;

  typedef logic [NumCols-1:0][ElemW-1:0] elem_row_t;

  // one finished tile waiting for the requant side
  typedef struct packed {
    elem_row_t        top;
    elem_row_t        bot;
    logic [ElemW-1:0] bias;
    logic [ElemW-1:0] scale;
  } tile_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

[src/wgrq_front.sv]
`timescale 1ns / 1ps

module wgrq_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               tile_row_i,
  input  logic signed [31:0]       elem_col0_i,
  input  logic signed [31:0]       elem_col1_i,
  input  logic signed [31:0]       elem_col2_i,
  input  logic signed [31:0]       elem_col3_i,
  input  logic signed [31:0]       chan_bias_i,
  input  logic signed [31:0]       chan_scale_i,
  input  wgrq_pkg::q_status_t      q_status_i,
  output logic                     push_o,
  output wgrq_pkg::tile_t          push_tile_o
);
  import wgrq_pkg::*;

  elem_row_t elem;
  elem_row_t top_q, top_d;
  elem_row_t bot_q, bot_d;
  logic      accept;

  assign elem       = {elem_col3_i, elem_col2_i, elem_col1_i, elem_col0_i};
  assign in_stall_o = q_status_i.full && (tile_row_i == ROW_M3);
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = accept && (tile_row_i == ROW_M3);

  always_comb begin
    top_d             = top_q;
    bot_d             = bot_q;
    push_tile_o.top   = top_q;
    push_tile_o.bias  = chan_bias_i;
    push_tile_o.scale = chan_scale_i;
    for (int c = 0; c < NumCols; c++) begin
      push_tile_o.bot[c] = bot_q[c] + elem[c];
      case (tile_row_i)
        ROW_M0: begin
          top_d[c] = top_q[c] + elem[c];
        end
        ROW_M1: begin
          top_d[c] = top_q[c] + elem[c];
          bot_d[c] = bot_q[c] + elem[c];
        end
        ROW_M2: begin
          top_d[c] = top_q[c] + elem[c];
          bot_d[c] = bot_q[c] - elem[c];
        end
        default: begin
          // tile complete, start the next one fresh
          top_d[c] = '0;
          bot_d[c] = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= '0;
      bot_q <= '0;
    end else if (accept) begin
      top_q <= top_d;
      bot_q <= bot_d;
    end
  end

endmodule

[src/wgrq_fifo.sv]
`timescale 1ns / 1ps

module wgrq_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  wgrq_pkg::tile_t     push_tile_i,
  input  logic                pop_i,
  output wgrq_pkg::tile_t     head_o,
  output wgrq_pkg::q_status_t status_o
);
  import wgrq_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  tile_t            mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign status_o.empty = (cnt_q == '0);
  assign status_o.full  = (cnt_q == CntW'(Depth));
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_tile_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[src/wgrq_back.sv]
`timescale 1ns / 1ps

module wgrq_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wgrq_pkg::tile_t     head_i,
  input  wgrq_pkg::q_status_t q_status_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [7:0]   out_value_o,
  output logic                out_row_o,
  output logic                out_col_o,
  output logic                out_last_o
);
  import wgrq_pkg::*;

  localparam int unsigned QW = ProdW - FracW;
  localparam logic [FracW-1:0] HalfLsb = FracW'(1) << (FracW - 1);

  logic                    adv, issue;
  logic [1:0]              k_q;
  elem_row_t               sel;
  logic [ElemW-1:0]        sum_d;

  logic                    va_q;
  logic [1:0]              ka_q;
  logic signed [ElemW-1:0] sum_q, scale_q;

  logic                    vb_q;
  logic [1:0]              kb_q;
  logic signed [ProdW-1:0] prod_d, prod_q;

  logic signed [QW-1:0]    q_int;
  logic [FracW-1:0]        frac;
  logic                    round_up;
  logic signed [QW:0]      q_rnd;
  logic signed [ValueW-1:0] value_d;

  logic                    out_valid_q;
  logic signed [ValueW-1:0] out_value_q;
  logic                    out_row_q, out_col_q, out_last_q;

  assign adv   = !out_valid_q || !out_stall_i;
  assign issue = !q_status_i.empty && adv;
  assign pop_o = issue && (k_q == 2'd3);

  // column combine for result k: top row first, then bottom row
  always_comb begin
    sel = k_q[1] ? head_i.bot : head_i.top;
    if (k_q[0]) begin
      sum_d = sel[1] - sel[2] + sel[3] + head_i.bias;
    end else begin
      sum_d = sel[0] + sel[1] + sel[2] + head_i.bias;
    end
  end

  assign prod_d = sum_q * scale_q;

  // round half to even, then clamp to int8
  always_comb begin
    q_int    = prod_q[ProdW-1:FracW];
    frac     = prod_q[FracW-1:0];
    round_up = (frac > HalfLsb) || ((frac == HalfLsb) && q_int[0]);
    q_rnd    = {q_int[QW-1], q_int} + (QW + 1)'(round_up);
    if (q_rnd > (QW + 1)'(signed'(127))) begin
      value_d = 8'sd127;
    end else if (q_rnd < (QW + 1)'(signed'(-128))) begin
      value_d = -8'sd128;
    end else begin
      value_d = q_rnd[ValueW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      va_q        <= 1'b0;
      vb_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      if (issue) begin
        k_q <= k_q + 1'b1;
      end
      va_q        <= issue;
      vb_q        <= va_q;
      out_valid_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sum_q       <= sum_d;
      scale_q     <= head_i.scale;
      ka_q        <= k_q;
      prod_q      <= prod_d;
      kb_q        <= ka_q;
      out_value_q <= value_d;
      out_row_q   <= kb_q[1];
      out_col_q   <= kb_q[0];
      out_last_q  <= (kb_q == 2'd3);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign out_last_o  = out_last_q;

endmodule

[src/winograd_f2x3_output_requant_top.sv]
`timescale 1ns / 1ps

// Winograd F(2x2,3x3) output transform with int8 requantization. One item per
// cycle carries one row of a 4x4 int32 tile; rows 0..2 only update the running
// top and bottom partial rows, and the row-3 item closes the tile and queues
// it. The back end then emits the four pixels (0,0), (0,1), (1,0), (1,1), one
// per cycle while out_stall_i is low, each as (sum + bias) * Q8.24 scale,
// rounded half to even and saturated to int8; out_last_o marks the fourth. The
// queue is written on the edge that accepts the row-3 item, and the first
// result then passes the column sum, multiply and round-and-clamp registers;
// with neither side stalling, a streamed tile sustains one item in and one
// result out per cycle. The tile queue holds QueueDepth tiles; in_stall_o
// rises only on a row-3 item while that queue is full.
module winograd_f2x3_output_requant_top #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         tile_row_i,
  input  logic signed [31:0] elem_col0_i,
  input  logic signed [31:0] elem_col1_i,
  input  logic signed [31:0] elem_col2_i,
  input  logic signed [31:0] elem_col3_i,
  input  logic signed [31:0] chan_bias_i,
  input  logic signed [31:0] chan_scale_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [7:0]  out_value_o,
  output logic               out_row_o,
  output logic               out_col_o,
  output logic               out_last_o
);
  import wgrq_pkg::*;

  tile_t     push_tile, head;
  q_status_t q_status;
  logic      push, pop;

  wgrq_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .tile_row_i   (tile_row_i),
    .elem_col0_i  (elem_col0_i),
    .elem_col1_i  (elem_col1_i),
    .elem_col2_i  (elem_col2_i),
    .elem_col3_i  (elem_col3_i),
    .chan_bias_i  (chan_bias_i),
    .chan_scale_i (chan_scale_i),
    .q_status_i   (q_status),
    .push_o       (push),
    .push_tile_o  (push_tile)
  );

  wgrq_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_tile_i (push_tile),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (q_status)
  );

  wgrq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_value_o (out_value_o),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .out_last_o  (out_last_o)
  );

endmodule

[src/wgrq_checker.sv]
`timescale 1ns / 1ps

module wgrq_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic [1:0]        tile_row_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic signed [7:0] out_value_o,
  input logic              out_row_o,
  input logic              out_col_o,
  input logic              out_last_o
);
  import wgrq_pkg::*;

  logic       in_acc, out_acc, tile_in, tile_out;
  logic [1:0] pos_q;
  logic [7:0] pend_q;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_acc  = out_valid_o && !out_stall_i;
  assign tile_in  = in_acc && (tile_row_i == ROW_M3);
  assign tile_out = out_acc && out_last_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      pend_q <= '0;
    end else begin
      if (out_acc) begin
        pos_q <= pos_q + 1'b1;
      end
      if (tile_in && !tile_out) begin
        pend_q <= pend_q + 1'b1;
      end else if (tile_out && !tile_in) begin
        pend_q <= pend_q - 1'b1;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_value_o))
    else $error("stalled result changed");

  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_last_o == (out_row_o && out_col_o)))
    else $error("last flag not on pixel (1,1)");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({out_row_o, out_col_o} == pos_q))
    else $error("result out of order");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pend_q != '0))
    else $error("result without a completed tile");

endmodule

bind winograd_f2x3_output_requant_top wgrq_checker u_wgrq_checker (.*);
